@@ src/rau_pkg.sv @@
// rau_pkg: widths, operation codes and stage payload types of the rational arithmetic unit.
// Shared by every module under src; depends on nothing.
`default_nettype none
package rau_pkg;

  localparam int unsigned OpW      = 16;                 // operand field width
  localparam int unsigned MagW     = 2 * OpW;            // magnitude of any cross product
  localparam int unsigned ShW      = $clog2(MagW + 1);   // count of common factors of two
  localparam int unsigned GcdSteps = 2 * MagW;           // binary GCD steps to settle
  localparam int unsigned NumW     = 34;
  localparam int unsigned DenW     = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // Unreduced (or reduced) fraction in sign-magnitude form.
  typedef struct packed {
    logic            st;
    logic            neg;
    logic [MagW-1:0] num;
    logic [MagW-1:0] den;
  } frac_t;

endpackage
`default_nettype wire

@@ src/rau_front.sv @@
// rau_front: operand split, cross products and sign-magnitude sum (three stages).
// Depends on rau_pkg.
`default_nettype none
module rau_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [1:0]                req_type_i,
  input  logic [rau_pkg::OpW-1:0]   a_num_i,
  input  logic [rau_pkg::OpW-1:0]   a_den_i,
  input  logic [rau_pkg::OpW-1:0]   b_num_i,
  input  logic [rau_pkg::OpW-1:0]   b_den_i,
  output logic                      valid_o,
  output rau_pkg::frac_t            frac_o
);
  import rau_pkg::*;

  // stage A: sign and magnitude
  logic            va_q, vb_q, vc_q;
  op_e             op_a_q;
  logic            an_a_q, bn_a_q, bad_a_q;
  logic [OpW-1:0]  am_a_q, bm_a_q, ad_a_q, bd_a_q;
  logic [OpW-1:0]  am_d, bm_d;
  logic            bad_d;

  assign am_d  = a_num_i[OpW-1] ? (~a_num_i + 1'b1) : a_num_i;
  assign bm_d  = b_num_i[OpW-1] ? (~b_num_i + 1'b1) : b_num_i;
  assign bad_d = (a_den_i == '0) || (b_den_i == '0) ||
                 ((op_e'(req_type_i) == OP_DIV) && (b_num_i == '0));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_a_q  <= op_e'(req_type_i);
      an_a_q  <= a_num_i[OpW-1];
      bn_a_q  <= b_num_i[OpW-1];
      am_a_q  <= am_d;
      bm_a_q  <= bm_d;
      ad_a_q  <= a_den_i;
      bd_a_q  <= b_den_i;
      bad_a_q <= bad_d;
    end
  end

  // stage B: three multipliers
  logic [MagW-1:0] pa_b_q, pb_b_q, pd_b_q;
  logic            an_b_q, sb_b_q, bad_b_q, sum_b_q, xs_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_b_q  <= am_a_q * ((op_a_q == OP_MUL) ? bm_a_q : bd_a_q);
      pb_b_q  <= bm_a_q * ad_a_q;
      pd_b_q  <= ad_a_q * ((op_a_q == OP_DIV) ? bm_a_q : bd_a_q);
      an_b_q  <= an_a_q;
      sb_b_q  <= (op_a_q == OP_SUB) ? ~bn_a_q : bn_a_q;
      xs_b_q  <= an_a_q ^ bn_a_q;
      sum_b_q <= (op_a_q == OP_ADD) || (op_a_q == OP_SUB);
      bad_b_q <= bad_a_q;
    end
  end

  // stage C: sign-magnitude add, zero and error cases
  frac_t           frac_q, frac_d;
  logic [MagW-1:0] m_d;
  logic            s_d;

  always_comb begin
    if (!sum_b_q) begin
      m_d = pa_b_q;
      s_d = xs_b_q;
    end else if (an_b_q == sb_b_q) begin
      m_d = pa_b_q + pb_b_q;
      s_d = an_b_q;
    end else if (pa_b_q >= pb_b_q) begin
      m_d = pa_b_q - pb_b_q;
      s_d = an_b_q;
    end else begin
      m_d = pb_b_q - pa_b_q;
      s_d = sb_b_q;
    end
    frac_d.st  = bad_b_q;
    frac_d.neg = s_d;
    frac_d.num = m_d;
    frac_d.den = pd_b_q;
    if (bad_b_q || (m_d == '0)) begin
      frac_d.neg = 1'b0;
      frac_d.num = '0;
      frac_d.den = MagW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      frac_q <= frac_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  assign valid_o = vc_q;
  assign frac_o  = frac_q;
endmodule
`default_nettype wire

@@ src/rau_gcd.sv @@
// rau_gcd: binary GCD of numerator and denominator magnitudes, one step per stage.
// Depends on rau_pkg.
`default_nettype none
module rau_gcd (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  rau_pkg::frac_t             frac_i,
  output logic                       valid_o,
  output rau_pkg::frac_t             frac_o,
  output logic [rau_pkg::MagW-1:0]   gcd_o
);
  import rau_pkg::*;

  typedef struct packed {
    frac_t           f;
    logic [MagW-1:0] x;
    logic [MagW-1:0] y;
    logic [ShW-1:0]  k;
  } gst_t;

  function automatic gst_t gcd_step(gst_t s);
    gst_t r;
    r = s;
    if ((s.x == '0) || (s.y == '0)) begin
      r = s;
    end else if (!s.x[0] && !s.y[0]) begin
      r.x = s.x >> 1;
      r.y = s.y >> 1;
      r.k = s.k + 1'b1;
    end else if (!s.x[0]) begin
      r.x = s.x >> 1;
    end else if (!s.y[0]) begin
      r.y = s.y >> 1;
    end else if (s.x >= s.y) begin
      r.x = (s.x - s.y) >> 1;
    end else begin
      r.y = (s.y - s.x) >> 1;
    end
    return r;
  endfunction

  gst_t            st_in;
  gst_t            s_q [GcdSteps];
  logic            v_q [GcdSteps];
  logic            vo_q;
  frac_t           fo_q;
  logic [MagW-1:0] g_q;

  assign st_in.f = frac_i;
  assign st_in.x = frac_i.num;
  assign st_in.y = frac_i.den;
  assign st_in.k = '0;

  for (genvar i = 0; i < GcdSteps; i++) begin : g_step
    if (i == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i) s_q[i] <= gcd_step(st_in);
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) v_q[i] <= 1'b0;
        else if (en_i) v_q[i] <= valid_i;
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i) s_q[i] <= gcd_step(s_q[i-1]);
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) v_q[i] <= 1'b0;
        else if (en_i) v_q[i] <= v_q[i-1];
      end
    end
  end

  // restore the common power of two
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fo_q <= s_q[GcdSteps-1].f;
      g_q  <= (s_q[GcdSteps-1].x | s_q[GcdSteps-1].y) << s_q[GcdSteps-1].k;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (en_i) vo_q <= v_q[GcdSteps-1];
  end

  assign valid_o = vo_q;
  assign frac_o  = fo_q;
  assign gcd_o   = g_q;
endmodule
`default_nettype wire

@@ src/rau_div.sv @@
// rau_div: restoring division of numerator and denominator by the GCD, one bit per stage.
// Depends on rau_pkg.
`default_nettype none
module rau_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  rau_pkg::frac_t            frac_i,
  input  logic [rau_pkg::MagW-1:0]  gcd_i,
  output logic                      valid_o,
  output rau_pkg::frac_t            frac_o
);
  import rau_pkg::*;

  typedef struct packed {
    logic            st;
    logic            neg;
    logic [MagW-1:0] g;
    logic [MagW-1:0] rn;   // partial remainders
    logic [MagW-1:0] rd;
    logic [MagW-1:0] qn;   // dividend bits out, quotient bits in
    logic [MagW-1:0] qd;
  } dst_t;

  function automatic dst_t div_step(dst_t s);
    dst_t          r;
    logic [MagW:0] tn, td;
    r  = s;
    tn = {s.rn, s.qn[MagW-1]};
    td = {s.rd, s.qd[MagW-1]};
    if (tn >= {1'b0, s.g}) tn = tn - {1'b0, s.g};
    if (td >= {1'b0, s.g}) td = td - {1'b0, s.g};
    r.qn = {s.qn[MagW-2:0], ({s.rn, s.qn[MagW-1]} >= {1'b0, s.g})};
    r.qd = {s.qd[MagW-2:0], ({s.rd, s.qd[MagW-1]} >= {1'b0, s.g})};
    r.rn = tn[MagW-1:0];
    r.rd = td[MagW-1:0];
    return r;
  endfunction

  dst_t d_in;
  dst_t s_q [MagW];
  logic v_q [MagW];

  assign d_in.st  = frac_i.st;
  assign d_in.neg = frac_i.neg;
  assign d_in.g   = gcd_i;
  assign d_in.rn  = '0;
  assign d_in.rd  = '0;
  assign d_in.qn  = frac_i.num;
  assign d_in.qd  = frac_i.den;

  for (genvar i = 0; i < MagW; i++) begin : g_bit
    if (i == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i) s_q[i] <= div_step(d_in);
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) v_q[i] <= 1'b0;
        else if (en_i) v_q[i] <= valid_i;
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i) s_q[i] <= div_step(s_q[i-1]);
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) v_q[i] <= 1'b0;
        else if (en_i) v_q[i] <= v_q[i-1];
      end
    end
  end

  assign valid_o    = v_q[MagW-1];
  assign frac_o.st  = s_q[MagW-1].st;
  assign frac_o.neg = s_q[MagW-1].neg;
  assign frac_o.num = s_q[MagW-1].qn;
  assign frac_o.den = s_q[MagW-1].qd;
endmodule
`default_nettype wire

@@ src/rational_arithmetic_unit_top.sv @@
// rational_arithmetic_unit_top: add, subtract, multiply or divide two fractions, reduced.
// Depends on rau_pkg, rau_front, rau_gcd and rau_div.
//
//   channel | signals                                      | direction
//   --------+----------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, req_type_i, a_*, b_* | sink
//   out     | out_valid_o, out_ready_i, res_*, status_o    | source
//
// A beat may enter every cycle while the output is not stalled.
// The binary GCD (one step per stage) and the bit-per-stage divider set the depth.
// Reset clears only the valid bits; data registers hold whatever they had.
// A stall on the output freezes the whole pipeline: nothing is dropped or repeated.
`default_nettype none
module rational_arithmetic_unit_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                req_type_i,
  input  logic [rau_pkg::OpW-1:0]   a_num_i,
  input  logic [rau_pkg::OpW-1:0]   a_den_i,
  input  logic [rau_pkg::OpW-1:0]   b_num_i,
  input  logic [rau_pkg::OpW-1:0]   b_den_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rau_pkg::NumW-1:0]  res_num_o,
  output logic [rau_pkg::DenW-1:0]  res_den_o,
  output logic                      status_o
);
  import rau_pkg::*;

  logic            en;
  logic            f_valid, g_valid, d_valid;
  frac_t           f_frac, g_frac, d_frac;
  logic [MagW-1:0] gcd;
  logic [NumW-1:0] mag;

  // advance everything unless the last stage holds a beat nobody takes
  assign en         = !d_valid || out_ready_i;
  assign in_ready_o = en;

  rau_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .req_type_i (req_type_i),
    .a_num_i    (a_num_i),
    .a_den_i    (a_den_i),
    .b_num_i    (b_num_i),
    .b_den_i    (b_den_i),
    .valid_o    (f_valid),
    .frac_o     (f_frac)
  );

  rau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .frac_i  (f_frac),
    .valid_o (g_valid),
    .frac_o  (g_frac),
    .gcd_o   (gcd)
  );

  rau_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (g_valid),
    .frac_i  (g_frac),
    .gcd_i   (gcd),
    .valid_o (d_valid),
    .frac_o  (d_frac)
  );

  // apply the sign to the reduced magnitude
  assign mag         = NumW'(d_frac.num);
  assign res_num_o   = d_frac.neg ? (~mag + 1'b1) : mag;
  assign res_den_o   = DenW'(d_frac.den);
  assign status_o    = d_frac.st;
  assign out_valid_o = d_valid;

`ifndef NO_ASSERTIONS
  a_den_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (res_den_o != '0))
    else $error("reduced denominator is zero");

  a_status_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> ((res_num_o == '0) && (res_den_o == DenW'(1))))
    else $error("error beat is not 0/1");

  a_zero_canon : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (res_num_o == '0)) |-> (res_den_o == DenW'(1)))
    else $error("zero result not reduced to 0/1");
`endif
endmodule
`default_nettype wire
